// ===== sv/clpa_pkg.sv =====
// Shared constants, types and the sequencer state set for the CPU load averager.
package clpa_pkg;

    // Field and result widths.
    localparam int TICK_W         = 40;
    localparam int PCT_W          = 7;
    localparam int HELD_W         = 10;
    localparam int PCT_MAX        = 100;

    // Seven tick counters per sample; the first five are the busy ones.
    localparam int NUM_FIELDS     = 7;
    localparam int BUSY_FIELDS    = 5;

    // Shared adder width: 100 times the busy sum needs 50 bits.
    localparam int ACC_W          = 50;

    // Quotients are percentages, so seven quotient bits are enough.
    localparam int QUO_W          = 7;
    localparam int DIV_SHIFT      = QUO_W - 1;

    // Step counter covers the longest phase (seven steps).
    localparam int STEP_W         = 3;
    localparam int LAST_SUM_STEP  = NUM_FIELDS - 1;
    localparam int LAST_BUSY_STEP = BUSY_FIELDS - 1;
    localparam int LAST_DIV_STEP  = QUO_W - 1;
    localparam int LAST_SCALE_STEP = 1;

    localparam int DEFAULT_WINDOW = 512;

    // Item kinds carried by the action field.
    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_QUERY  = 1'b1
    } action_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_SCALE,
        ST_LOAD_DIV,
        ST_RING_RD,
        ST_RING_SUB,
        ST_RING_ADD,
        ST_AVG_INIT,
        ST_AVG_DIV,
        ST_DONE
    } state_t;

    // Operation of the shared adder.
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [ACC_W-1:0]   a;
        logic [ACC_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic [ACC_W-1:0]   res;
        logic               carry;
    } alu_rsp_t;

endpackage

// ===== sv/clpa_if.sv =====
// Valid/ready channel interfaces for sample/query items and result items.
interface clpa_in_if
    import clpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [TICK_W-1:0] user_ticks;
    logic [TICK_W-1:0] nice_ticks;
    logic [TICK_W-1:0] system_ticks;
    logic [TICK_W-1:0] idle_ticks;
    logic [TICK_W-1:0] iowait_ticks;
    logic [TICK_W-1:0] irq_ticks;
    logic [TICK_W-1:0] softirq_ticks;

    modport source (
        output valid, action, user_ticks, nice_ticks, system_ticks, idle_ticks,
               iowait_ticks, irq_ticks, softirq_ticks,
        input  ready
    );

    modport sink (
        input  valid, action, user_ticks, nice_ticks, system_ticks, idle_ticks,
               iowait_ticks, irq_ticks, softirq_ticks,
        output ready
    );
endinterface

interface clpa_out_if
    import clpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PCT_W-1:0]  load_percent;
    logic [PCT_W-1:0]  average_percent;
    logic [HELD_W-1:0] samples_held;
    logic              divide_fault;

    modport source (
        output valid, load_percent, average_percent, samples_held, divide_fault,
        input  ready
    );

    modport sink (
        input  valid, load_percent, average_percent, samples_held, divide_fault,
        output ready
    );
endinterface

// ===== sv/clpa_alu.sv =====
// Shared 50-bit add/subtract unit with carry out (carry set on subtract means a >= b).
module clpa_alu
    import clpa_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ACC_W:0] full_sum;
    logic [ACC_W-1:0] b_eff;

    // Subtraction is addition of the inverted operand plus one.
    always_comb
    begin
        b_eff    = (req.op == ALU_SUB) ? ~req.b : req.b;
        full_sum = {1'b0, req.a} + {1'b0, b_eff} + {{ACC_W{1'b0}}, (req.op == ALU_SUB)};
        rsp.res   = full_sum[ACC_W-1:0];
        rsp.carry = full_sum[ACC_W];
    end

endmodule

// ===== sv/cpu_load_percent_averager.sv =====
// Top level of the CPU load averager: sequencer, ring memory and result register.
//
// The samples channel takes two kinds of item. A sample item (action 0) carries seven
// cumulative tick counters; the block computes floor(100 * busy / total) and, for a
// nonzero total, pushes that percentage into a ring of the last WINDOW samples, keeping
// a running sum. A query item (action 1) only reads the average. Every item produces
// exactly one result item on the results channel: this sample's percentage, the mean of
// the held samples, the number held, and a fault flag for a zero total or an empty ring.
// All arithmetic goes through one 50-bit adder under a small sequencer, one step per
// cycle, so the adder sets the timing: a sample runs the sum, scale, division and ring
// steps and then the average division (a zero total skips to the average, an empty ring
// skips its division), and a query runs only the average division. samples.ready is high
// only in the idle state, so a new item is taken only once the last one is handed over.
// The result sits in an output register, so the next item is accepted while an earlier
// result still waits; if the receiver stalls longer, the sequencer holds its finished
// result and stays busy until the output register frees.
// Reset clears the slot pointer, count and sum; the ring holds no valid data until written.
module cpu_load_percent_averager
    import clpa_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  logic       clk,
    input  logic       rst_n,
    clpa_in_if.sink    samples,
    clpa_out_if.source results
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * PCT_MAX + 1);

    // Control state.
    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;

    // Working registers of the datapath.
    logic [TICK_W-1:0]   tick_reg [NUM_FIELDS];
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    dvs_reg, dvs_next;
    logic [ACC_W-1:0]    busy_reg, busy_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [PCT_W-1:0]    load_reg, load_next;
    logic [PCT_W-1:0]    avg_reg, avg_next;
    logic                fault_reg, fault_next;

    // Result register.
    logic [PCT_W-1:0]    res_load_reg;
    logic [PCT_W-1:0]    res_avg_reg;
    logic [HELD_W-1:0]   res_held_reg;
    logic                res_fault_reg;

    // Ring memory and its registered read port.
    logic [PCT_W-1:0]    ring_mem [WINDOW];
    logic [PCT_W-1:0]    rd_reg;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    logic                accept;
    logic                ring_full;
    logic                emit;
    logic [QUO_W-1:0]    quo_shifted;

    clpa_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign ring_full     = (count_reg == CNT_W'(WINDOW));
    assign emit          = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);
    assign quo_shifted   = {quo_reg[QUO_W-2:0], alu_rsp.carry};

    assign results.valid           = out_valid_reg;
    assign results.load_percent    = res_load_reg;
    assign results.average_percent = res_avg_reg;
    assign results.samples_held    = res_held_reg;
    assign results.divide_fault    = res_fault_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (samples.action == ACT_QUERY) ? ST_AVG_INIT : ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (step_reg == STEP_W'(LAST_SUM_STEP))
                begin
                    state_next = (alu_rsp.res == '0) ? ST_AVG_INIT : ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (step_reg == STEP_W'(LAST_SCALE_STEP))
                begin
                    state_next = ST_LOAD_DIV;
                end
            end
            ST_LOAD_DIV:
            begin
                if (step_reg == STEP_W'(LAST_DIV_STEP))
                begin
                    state_next = ST_RING_RD;
                end
            end
            ST_RING_RD:  state_next = ST_RING_SUB;
            ST_RING_SUB: state_next = ST_RING_ADD;
            ST_RING_ADD: state_next = ST_AVG_INIT;
            ST_AVG_INIT:
            begin
                state_next = (count_reg == '0) ? ST_DONE : ST_AVG_DIV;
            end
            ST_AVG_DIV:
            begin
                if (step_reg == STEP_W'(LAST_DIV_STEP))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_req.op = ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (state_reg)
            ST_SUM:
            begin
                alu_req.a = acc_reg;
                alu_req.b = ACC_W'(tick_reg[step_reg]);
            end
            ST_SCALE:
            begin
                // 100 * busy = busy*64 + busy*32 + busy*4, over two additions.
                if (step_reg == '0)
                begin
                    alu_req.a = busy_reg << 6;
                    alu_req.b = busy_reg << 5;
                end
                else
                begin
                    alu_req.a = acc_reg;
                    alu_req.b = busy_reg << 2;
                end
            end
            ST_LOAD_DIV, ST_AVG_DIV:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = acc_reg;
                alu_req.b  = dvs_reg;
            end
            ST_RING_SUB:
            begin
                // The oldest sample leaves the sum only once the ring is full.
                alu_req.op = ALU_SUB;
                alu_req.a  = ACC_W'(sum_reg);
                alu_req.b  = ring_full ? ACC_W'(rd_reg) : '0;
            end
            ST_RING_ADD:
            begin
                alu_req.a = ACC_W'(sum_reg);
                alu_req.b = ACC_W'(load_reg);
            end
            default:
            begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    // Datapath and counter updates per sequencer step.
    always_comb
    begin
        step_next      = step_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        dvs_next       = dvs_reg;
        busy_next      = busy_reg;
        quo_next       = quo_reg;
        load_next      = load_reg;
        avg_next       = avg_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg && !results.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next  = '0;
                    acc_next   = '0;
                    load_next  = '0;
                    avg_next   = '0;
                    fault_next = 1'b0;
                end
            end
            ST_SUM:
            begin
                acc_next  = alu_rsp.res;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(LAST_BUSY_STEP))
                begin
                    busy_next = alu_rsp.res;
                end
                if (step_reg == STEP_W'(LAST_SUM_STEP))
                begin
                    // Total is final; the divisor starts at total shifted to the top bit.
                    dvs_next  = alu_rsp.res << DIV_SHIFT;
                    step_next = '0;
                    if (alu_rsp.res == '0)
                    begin
                        fault_next = 1'b1;
                    end
                end
            end
            ST_SCALE:
            begin
                acc_next  = alu_rsp.res;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(LAST_SCALE_STEP))
                begin
                    step_next = '0;
                    quo_next  = '0;
                end
            end
            ST_LOAD_DIV, ST_AVG_DIV:
            begin
                // One restoring division step: keep the difference when it did not borrow.
                if (alu_rsp.carry)
                begin
                    acc_next = alu_rsp.res;
                end
                quo_next  = quo_shifted;
                dvs_next  = dvs_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(LAST_DIV_STEP))
                begin
                    step_next = '0;
                    if (state_reg == ST_LOAD_DIV)
                    begin
                        load_next = quo_shifted;
                    end
                    else
                    begin
                        avg_next = quo_shifted;
                    end
                end
            end
            ST_RING_SUB:
            begin
                sum_next = alu_rsp.res[SUM_W-1:0];
            end
            ST_RING_ADD:
            begin
                sum_next = alu_rsp.res[SUM_W-1:0];
                if (slot_reg == SLOT_W'(WINDOW - 1))
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                if (!ring_full)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_AVG_INIT:
            begin
                if (count_reg == '0)
                begin
                    fault_next = 1'b1;
                    avg_next   = '0;
                end
                else
                begin
                    acc_next  = ACC_W'(sum_reg);
                    dvs_next  = ACC_W'(count_reg) << DIV_SHIFT;
                    quo_next  = '0;
                    step_next = '0;
                end
            end
            ST_DONE:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        dvs_reg   <= dvs_next;
        busy_reg  <= busy_next;
        quo_reg   <= quo_next;
        load_reg  <= load_next;
        avg_reg   <= avg_next;
        fault_reg <= fault_next;
    end

    // Capture the tick counters, busy ones first, then the two idle ones.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg[0] <= samples.user_ticks;
            tick_reg[1] <= samples.nice_ticks;
            tick_reg[2] <= samples.system_ticks;
            tick_reg[3] <= samples.irq_ticks;
            tick_reg[4] <= samples.softirq_ticks;
            tick_reg[5] <= samples.idle_ticks;
            tick_reg[6] <= samples.iowait_ticks;
        end
    end

    // Result register, loaded when the sequencer hands over a finished item.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_load_reg  <= load_reg;
            res_avg_reg   <= avg_reg;
            res_held_reg  <= HELD_W'(count_reg);
            res_fault_reg <= fault_reg;
        end
    end

    // Ring memory: one write in the add step, registered read at the current slot.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RING_ADD)
        begin
            ring_mem[slot_reg] <= load_reg;
        end
        rd_reg <= ring_mem[slot_reg];
    end

    // The held count never passes the window size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW))
        else $error("held sample count exceeds the window");

    // The running sum stays within 100 per held sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(sum_reg) <= 32'(count_reg) * 32'(PCT_MAX))
        else $error("running sum exceeds the bound of the held samples");

    // Any result shown carries percentages no larger than 100.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_load_reg <= PCT_W'(PCT_MAX)) && (res_avg_reg <= PCT_W'(PCT_MAX)))
        else $error("result percentage out of range");

    // The ring is only written while the sequencer is in the middle of a sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RING_ADD) |-> $past(state_reg) == ST_RING_SUB)
        else $error("ring write outside the sample update sequence");

endmodule
